// File: design/shared_tagged_byte_pool_core_assert.svh
// Assertion macros used by the byte pool core.
`ifndef SHARED_TAGGED_BYTE_POOL_CORE_ASSERT_SVH
`define SHARED_TAGGED_BYTE_POOL_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, off while reset is asserted.
`define STBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset.
`define STBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STBP_ASSERT(lbl, prop, msg)
`define STBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/stbp_pkg.sv
// Shared constants, types and helpers of the byte pool.
package stbp_pkg;

    localparam int POOL_DEPTH   = 128;
    localparam int SLOT_W       = $clog2(POOL_DEPTH);
    localparam int COUNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int TAG_W        = 3;
    localparam int BYTE_W       = 8;
    localparam int DEVICE_SLOTS = 6;

    localparam logic             CMD_PUT   = 1'b0;
    localparam logic             CMD_GET   = 1'b1;
    localparam logic [TAG_W-1:0] BLANK_TAG = 3'd0;
    localparam logic [TAG_W-1:0] DEV_FIRST = 3'd1;
    localparam logic [TAG_W-1:0] DEV_LAST  = 3'd5;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [TAG_W-1:0]  tag;
    } tag_wr_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [SLOT_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } byte_req_t;

    // Step one slot forward, wrapping at the end of the pool.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(POOL_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// File: design/stbp_tag_store.sv
// Owner tag memory with per-slot valid bits so reset reads every slot as blank.
module stbp_tag_store
    import stbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tag_wr_t           wr,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [TAG_W-1:0]  rd_tag
);

    logic [TAG_W-1:0]      tag_mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] vld_reg;
    logic [TAG_W-1:0]      rd_tag_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tag_mem[wr.addr] <= wr.tag;
        end
        if (rd_en)
        begin
            rd_tag_reg <= tag_mem[rd_addr];
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_tag = rd_vld_reg ? rd_tag_reg : BLANK_TAG;

endmodule

// File: design/stbp_byte_store.sv
// Byte data memory, one port, registered read.
module stbp_byte_store
    import stbp_pkg::*;
(
    input  logic              clk,
    input  byte_req_t         req,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] byte_mem [POOL_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            byte_mem[req.addr] <= req.data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= byte_mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/shared_tagged_byte_pool_core.sv
// Byte pool shared by five devices: input channel, scan sequencer, result register.
//
// Input channel: command (0 put, 1 get), device (1..5), write_data, handshake
// in_valid / in_stall. Output channel: read_data, done_res, device_count,
// free_count, handshake out_valid / out_stall. An item moves when valid is high
// and stall is low.
// One item at a time: in_stall is high from acceptance until the result is
// loaded into the output register. A put scans the tag memory from the
// device's last write slot to the first blank slot, a get from its last read
// slot to the first slot it owns, one slot per cycle through the tag memory
// read port and one compare unit. An item whose match lies k slots ahead
// (k = 0..127) raises out_valid after the scan, the hit state and the
// response state; a full pool, an empty device or a bad device number goes
// straight to the response state. The next item waits for a return to idle.
// Reset clears every tag (valid bits), the counts (free = 128) and the slot
// pointers at once; the block takes items right after reset.
// A stalled output holds its result; the next item is accepted meanwhile and
// waits in its final state until the output register is free.
module shared_tagged_byte_pool_core
    import stbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              command,
    input  logic [2:0]        device,
    input  logic [7:0]        write_data,
    input  logic              in_valid,
    output logic              in_stall,
    output logic [7:0]        read_data,
    output logic              done_res,
    output logic [7:0]        device_count,
    output logic [7:0]        free_count,
    output logic              out_valid,
    input  logic              out_stall
);

`include "shared_tagged_byte_pool_core_assert.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HIT  = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               cmd_reg, cmd_next;
    logic [TAG_W-1:0]   dev_reg, dev_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic [SLOT_W-1:0]  scan_reg, scan_next;
    logic [SLOT_W-1:0]  pend_slot_reg, pend_slot_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [SLOT_W-1:0]  miss_cnt_reg, miss_cnt_next;
    logic [SLOT_W-1:0]  hit_slot_reg, hit_slot_next;
    logic               found_reg, found_next;

    logic [COUNT_W-1:0] cnt_reg    [DEVICE_SLOTS];
    logic [SLOT_W-1:0]  wr_ptr_reg [DEVICE_SLOTS];
    logic [SLOT_W-1:0]  rd_ptr_reg [DEVICE_SLOTS];

    logic [7:0]         read_data_reg, read_data_next;
    logic               done_res_reg, done_res_next;
    logic [7:0]         dev_cnt_reg, dev_cnt_next;
    logic [7:0]         free_cnt_reg, free_cnt_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_dev_ok;
    logic               dev_ok;
    logic               out_free;
    logic               is_match;
    logic [TAG_W-1:0]   tag_q;
    logic [BYTE_W-1:0]  byte_q;
    tag_wr_t            tag_wr;
    byte_req_t          byte_req;

    stbp_tag_store u_tag_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tag_wr),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (scan_reg),
        .rd_tag  (tag_q)
    );

    stbp_byte_store u_byte_store (
        .clk     (clk),
        .req     (byte_req),
        .rd_data (byte_q)
    );

    assign in_dev_ok = (device >= DEV_FIRST) && (device <= DEV_LAST);
    assign dev_ok    = (dev_reg >= DEV_FIRST) && (dev_reg <= DEV_LAST);
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_match  = (cmd_reg == CMD_PUT) ? (tag_q == BLANK_TAG) : (tag_q == dev_reg);

    always_comb
    begin
        tag_wr.en       = (state_reg == ST_HIT);
        tag_wr.addr     = hit_slot_reg;
        tag_wr.tag      = (cmd_reg == CMD_PUT) ? dev_reg : BLANK_TAG;
        byte_req.wr_en  = (state_reg == ST_HIT) && (cmd_reg == CMD_PUT);
        byte_req.rd_en  = (state_reg == ST_HIT) && (cmd_reg == CMD_GET);
        byte_req.addr   = hit_slot_reg;
        byte_req.data   = data_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        dev_next       = dev_reg;
        data_next      = data_reg;
        scan_next      = scan_reg;
        pend_slot_next = pend_slot_reg;
        pend_vld_next  = 1'b0;
        miss_cnt_next  = miss_cnt_reg;
        hit_slot_next  = hit_slot_reg;
        found_next     = found_reg;
        read_data_next = read_data_reg;
        done_res_next  = done_res_reg;
        dev_cnt_next   = dev_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = command;
                    dev_next      = device;
                    data_next     = write_data;
                    found_next    = 1'b0;
                    miss_cnt_next = '0;
                    scan_next     = (command == CMD_PUT) ? wr_ptr_reg[device]
                                                         : rd_ptr_reg[device];
                    // Counts tell up front whether a scan can succeed.
                    if (!in_dev_ok)
                        state_next = ST_RESP;
                    else if (command == CMD_PUT && cnt_reg[0] == '0)
                        state_next = ST_RESP;
                    else if (command == CMD_GET && cnt_reg[device] == '0)
                        state_next = ST_RESP;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Read issued at scan_reg, compared in the following cycle.
                scan_next      = next_slot(scan_reg);
                pend_slot_next = scan_reg;
                pend_vld_next  = 1'b1;
                if (pend_vld_reg)
                begin
                    if (is_match)
                    begin
                        hit_slot_next = pend_slot_reg;
                        found_next    = 1'b1;
                        pend_vld_next = 1'b0;
                        state_next    = ST_HIT;
                    end
                    else if (miss_cnt_reg == SLOT_W'(POOL_DEPTH - 1))
                    begin
                        pend_vld_next = 1'b0;
                        state_next    = ST_RESP;
                    end
                    else
                    begin
                        miss_cnt_next = miss_cnt_reg + 1'b1;
                    end
                end
            end
            ST_HIT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    read_data_next = (found_reg && cmd_reg == CMD_GET) ? byte_q : 8'd0;
                    done_res_next  = found_reg;
                    dev_cnt_next   = dev_ok ? 8'(cnt_reg[dev_reg]) : 8'd0;
                    free_cnt_next  = 8'(cnt_reg[0]);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        dev_reg       <= dev_next;
        data_reg      <= data_next;
        scan_reg      <= scan_next;
        pend_slot_reg <= pend_slot_next;
        miss_cnt_reg  <= miss_cnt_next;
        hit_slot_reg  <= hit_slot_next;
        read_data_reg <= read_data_next;
        done_res_reg  <= done_res_next;
        dev_cnt_reg   <= dev_cnt_next;
        free_cnt_reg  <= free_cnt_next;
    end

    // Counts and slot pointers change only on a hit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEVICE_SLOTS; i++)
            begin
                cnt_reg[i]    <= (i == 0) ? COUNT_W'(POOL_DEPTH) : '0;
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_HIT)
        begin
            if (cmd_reg == CMD_PUT)
            begin
                wr_ptr_reg[dev_reg] <= hit_slot_reg;
                cnt_reg[dev_reg]    <= cnt_reg[dev_reg] + 1'b1;
                cnt_reg[0]          <= cnt_reg[0] - 1'b1;
            end
            else
            begin
                rd_ptr_reg[dev_reg] <= hit_slot_reg;
                cnt_reg[dev_reg]    <= cnt_reg[dev_reg] - 1'b1;
                cnt_reg[0]          <= cnt_reg[0] + 1'b1;
            end
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign read_data    = read_data_reg;
    assign done_res     = done_res_reg;
    assign device_count = dev_cnt_reg;
    assign free_count   = free_cnt_reg;
    assign out_valid    = out_valid_reg;

    `STBP_ASSERT(a_count_sum,
        (32'(cnt_reg[0]) + 32'(cnt_reg[1]) + 32'(cnt_reg[2]) + 32'(cnt_reg[3])
         + 32'(cnt_reg[4]) + 32'(cnt_reg[5])) == POOL_DEPTH,
        "slot counts do not add up to the pool depth")
    `STBP_ASSERT(a_put_has_room,
        (state_reg == ST_HIT && cmd_reg == CMD_PUT) |-> (cnt_reg[0] != '0),
        "put hit with no free slot")
    `STBP_ASSERT(a_get_has_byte,
        (state_reg == ST_HIT && cmd_reg == CMD_GET) |-> (cnt_reg[dev_reg] != '0),
        "get hit for a device holding nothing")
    `STBP_ASSERT(a_idle_holds,
        (state_reg == ST_IDLE && !in_valid) |=> (state_reg == ST_IDLE),
        "sequencer left idle without an item")
    `STBP_ASSERT(a_out_from_resp,
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP),
        "result appeared outside the response state")

endmodule

// File: sim/stbp_pool_checker.sv
`timescale 1ns / 1ps
// Byte pool checker: watches both channels, predicts every result and compares it.
module stbp_pool_checker
    import stbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       command,
    input  logic [2:0] device,
    input  logic [7:0] write_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] read_data,
    input  logic       done_res,
    input  logic [7:0] device_count,
    input  logic [7:0] free_count,
    input  logic       out_valid,
    input  logic       out_stall,
    output int         fail_count,
    output int         pending_results
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
        logic [7:0] device_count;
        logic [7:0] free_count;
    } pool_result_t;

    logic [BYTE_W-1:0] pool_bytes [POOL_DEPTH];
    logic [TAG_W-1:0]  pool_tags  [POOL_DEPTH];
    // entry 0 holds the blank slot count
    int unsigned       held       [DEVICE_SLOTS];
    int unsigned       put_ptr    [DEVICE_SLOTS];
    int unsigned       get_ptr    [DEVICE_SLOTS];
    pool_result_t      results_q  [$];
    int                errors = 0;

    task automatic clear_pool();
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            pool_bytes[i] = '0;
            pool_tags[i]  = BLANK_TAG;
        end
        for (int d = 0; d < DEVICE_SLOTS; d++)
        begin
            held[d]    = 0;
            put_ptr[d] = 0;
            get_ptr[d] = 0;
        end
        held[0] = POOL_DEPTH;
        results_q.delete();
    endtask

    function automatic int unsigned step_slot(input int unsigned s);
        return (s == POOL_DEPTH - 1) ? 0 : s + 1;
    endfunction

    task automatic predict_item(input logic cmd, input logic [2:0] dev, input logic [7:0] data);
        pool_result_t r;
        int unsigned  s;
        bit           hit;
        r   = '0;
        hit = 1'b0;
        if (dev >= DEV_FIRST && dev <= DEV_LAST)
        begin
            if (cmd == CMD_PUT)
            begin
                s = put_ptr[dev];
                if (held[0] != 0)
                begin
                    for (int n = 0; n < POOL_DEPTH && !hit; n++)
                    begin
                        if (pool_tags[s] == BLANK_TAG)
                        begin
                            hit           = 1'b1;
                            pool_tags[s]  = dev;
                            pool_bytes[s] = data;
                            put_ptr[dev]  = s;
                            held[dev]++;
                            held[0]--;
                        end
                        else
                            s = step_slot(s);
                    end
                end
            end
            else
            begin
                s = get_ptr[dev];
                if (held[dev] != 0)
                begin
                    for (int n = 0; n < POOL_DEPTH && !hit; n++)
                    begin
                        if (pool_tags[s] == dev)
                        begin
                            hit          = 1'b1;
                            pool_tags[s] = BLANK_TAG;
                            get_ptr[dev] = s;
                            r.read_data  = pool_bytes[s];
                            held[dev]--;
                            held[0]++;
                        end
                        else
                            s = step_slot(s);
                    end
                end
            end
            r.device_count = 8'(held[dev]);
        end
        r.done_res   = hit;
        r.free_count = 8'(held[0]);
        results_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        pool_result_t want;
        if (results_q.size() == 0)
        begin
            $error("result with no item outstanding: read_data %0d done_res %0d",
                   read_data, done_res);
            errors++;
        end
        else
        begin
            want = results_q.pop_front();
            check_field("read_data", want.read_data, read_data);
            check_field("done_res", 8'(want.done_res), 8'(done_res));
            check_field("device_count", want.device_count, device_count);
            check_field("free_count", want.free_count, free_count);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_pool();
            pending_results <= 0;
            fail_count      <= errors;
        end
        else
        begin
            // a result leaving now always belongs to an earlier item
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                predict_item(command, device, write_data);
            pending_results <= results_q.size();
            fail_count      <= errors;
        end
    end

endmodule

// File: sim/tb_shared_tagged_byte_pool_core.sv
`timescale 1ns / 1ps
// Testbench top of the byte pool: clock, reset, item stimulus, receiver stalls and verdict.
module tb_shared_tagged_byte_pool_core
    import stbp_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 160;

    localparam logic [2:0] DEV_NONE    = 3'd0;
    localparam logic [2:0] DEV_OVER_LO = 3'd6;
    localparam logic [2:0] DEV_OVER_HI = 3'd7;

    typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_NOISE} burst_kind_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       command    = CMD_PUT;
    logic [2:0] device     = DEV_FIRST;
    logic [7:0] write_data = 8'd0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [7:0] read_data;
    logic       done_res;
    logic [7:0] device_count;
    logic [7:0] free_count;
    logic       out_valid;
    logic       out_stall  = 1'b0;

    int         fail_count;
    int         pending_results;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    logic       hold_start     = 1'b0;
    int         hold_left      = 0;
    int         cycles         = 0;

    shared_tagged_byte_pool_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .device       (device),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .read_data    (read_data),
        .done_res     (done_res),
        .device_count (device_count),
        .free_count   (free_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

    stbp_pool_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .command         (command),
        .device          (device),
        .write_data      (write_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .read_data       (read_data),
        .done_res        (done_res),
        .device_count    (device_count),
        .free_count      (free_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: random stalls, or a long hold-off counted down here
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // in_valid is lowered only in the idle loop and in wait_results, so it never drops and rises in one step
    task automatic push_item(input logic cmd, input logic [2:0] dev, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        device     <= dev;
        write_data <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    task automatic send_random(input burst_kind_t kind);
        logic       cmd;
        logic [2:0] dev;
        case (kind)
            BURST_FILL:  cmd = CMD_PUT;
            BURST_DRAIN: cmd = CMD_GET;
            default:     cmd = 1'($urandom_range(1));
        endcase
        if (kind == BURST_NOISE || $urandom_range(99) < 3)
        begin
            case ($urandom_range(2))
                0:       dev = DEV_NONE;
                1:       dev = DEV_OVER_LO;
                default: dev = DEV_OVER_HI;
            endcase
        end
        else
            dev = 3'($urandom_range(DEV_LAST, DEV_FIRST));
        push_item(cmd, dev, 8'($urandom_range(255)));
    endtask

    task automatic run_bursts(input int n_items);
        burst_kind_t kind;
        int          len;
        int          sent;
        sent = 0;
        while (sent < n_items)
        begin
            kind = burst_kind_t'($urandom_range(3));
            len  = (kind == BURST_NOISE) ? $urandom_range(3, 1) : $urandom_range(60, 8);
            repeat (len) send_random(kind);
            if (kind != BURST_NOISE)
                sent += len;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes, empty devices, bad device numbers
        push_item(CMD_PUT, 3'd1, 8'h00);
        push_item(CMD_PUT, 3'd5, 8'hff);
        push_item(CMD_PUT, 3'd2, 8'ha5);
        push_item(CMD_GET, 3'd1, 8'hff);
        push_item(CMD_GET, 3'd1, 8'h00);
        push_item(CMD_GET, 3'd3, 8'h00);
        push_item(CMD_PUT, 3'd3, 8'h5a);
        push_item(CMD_GET, 3'd5, 8'h00);
        push_item(CMD_GET, 3'd2, 8'h00);
        push_item(CMD_GET, 3'd3, 8'h00);
        push_item(CMD_PUT, DEV_NONE, 8'h11);
        push_item(CMD_GET, DEV_OVER_LO, 8'h22);
        push_item(CMD_PUT, DEV_OVER_HI, 8'hff);
        push_item(CMD_GET, DEV_NONE, 8'h00);
        push_item(CMD_PUT, 3'd4, 8'h0f);
        push_item(CMD_PUT, 3'd4, 8'hf0);
        push_item(CMD_GET, 3'd4, 8'h00);
        push_item(CMD_GET, 3'd4, 8'h00);
        push_item(CMD_GET, 3'd4, 8'h00);
        push_item(CMD_GET, DEV_OVER_HI, 8'h00);
        wait_results();

        // fill past full so puts get dropped, then drain past empty
        repeat (140) send_random(BURST_FILL);
        repeat (140) send_random(BURST_DRAIN);
        run_bursts(20);
        wait_results();

        send_idle_pct <= 69;
        run_bursts(80);
        wait_results();

        send_idle_pct  <= 0;
        recv_stall_pct <= 69;
        run_bursts(80);
        wait_results();

        send_idle_pct  <= 33;
        recv_stall_pct <= 33;
        hold_start     <= 1'b1;
        @(posedge clk);
        hold_start     <= 1'b0;
        repeat (20) send_random(BURST_MIXED);
        run_bursts(60);

        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/stbp_pkg.sv
design/stbp_tag_store.sv
design/stbp_byte_store.sv
design/shared_tagged_byte_pool_core.sv
sim/stbp_pool_checker.sv
sim/tb_shared_tagged_byte_pool_core.sv
